FILE: rtl/core/dfm_pkg.sv
package dfm_pkg;

	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_LATCH = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	localparam logic [1:0] REG_STALL_DRIVE_THRESHOLD = 2'd0;
	localparam logic [1:0] REG_STALL_TICK_LIMIT      = 2'd1;
	localparam logic [1:0] REG_LINE_LOST_TICK_LIMIT  = 2'd2;
	localparam logic [1:0] REG_INVALID_EDGE_LIMIT    = 2'd3;

	localparam int FAULT_LINE_LOST = 0;
	localparam int FAULT_IMU       = 1;
	localparam int FAULT_L_STALL   = 2;
	localparam int FAULT_R_STALL   = 3;
	localparam int FAULT_ENC_SIG   = 4;

	localparam logic [7:0] COUNT_MAX = 8'd255;

	localparam logic [14:0] RST_STALL_DRIVE_THRESHOLD = 15'd1000;
	localparam logic [7:0]  RST_STALL_TICK_LIMIT      = 8'd20;
	localparam logic [7:0]  RST_LINE_LOST_TICK_LIMIT  = 8'd50;
	localparam logic [15:0] RST_INVALID_EDGE_LIMIT    = 16'd10;

	typedef struct packed {
		logic tick;
		logic latch;
		logic clear;
	} ctl_t;

	typedef struct packed {
		logic stall_hit;
		logic edge_hit;
	} lane_flags_t;

	typedef struct packed {
		logic [4:0] faults;
		logic [7:0] line_lost_count;
	} result_t;

endpackage

FILE: rtl/core/dfm_in_if.sv
interface dfm_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         cmd;
	logic               line_present;
	logic               imu_ready;
	logic signed [15:0] left_drive;
	logic signed [15:0] right_drive;
	logic signed [15:0] left_encoder_delta;
	logic signed [15:0] right_encoder_delta;
	logic [31:0]        left_invalid_total;
	logic [31:0]        right_invalid_total;
	logic [4:0]         extra_fault_bits;

	modport source (
		output valid, cmd, line_present, imu_ready, left_drive, right_drive,
		output left_encoder_delta, right_encoder_delta,
		output left_invalid_total, right_invalid_total, extra_fault_bits,
		input  ready
	);
	modport sink (
		input  valid, cmd, line_present, imu_ready, left_drive, right_drive,
		input  left_encoder_delta, right_encoder_delta,
		input  left_invalid_total, right_invalid_total, extra_fault_bits,
		output ready
	);
endinterface

FILE: rtl/core/dfm_out_if.sv
interface dfm_out_if;
	logic       valid;
	logic       ready;
	logic [4:0] faults;
	logic [7:0] line_lost_count;

	modport source (output valid, faults, line_lost_count, input ready);
	modport sink (input valid, faults, line_lost_count, output ready);
endinterface

FILE: rtl/core/dfm_wheel_lane.sv
module dfm_wheel_lane (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dfm_pkg::ctl_t        ctl,
	input  logic signed [15:0]   drive,
	input  logic signed [15:0]   encoder_delta,
	input  logic [31:0]          invalid_total,
	input  logic [14:0]          stall_drive_threshold,
	input  logic [7:0]           stall_tick_limit,
	input  logic [15:0]          invalid_edge_limit,
	output dfm_pkg::lane_flags_t flags
);
	import dfm_pkg::*;

	logic [7:0]  stall_ticks_q;
	logic [31:0] invalid_prev_q;
	logic [15:0] magnitude;
	logic        stalled;
	logic [7:0]  stall_next;
	logic [31:0] growth;

	// two's complement magnitude, -32768 comes out as 16'h8000
	assign magnitude  = drive[15] ? (~drive + 16'd1) : drive;
	assign stalled    = (magnitude > {1'b0, stall_drive_threshold}) && (encoder_delta == '0);
	assign stall_next = !stalled ? 8'd0 :
		(stall_ticks_q < COUNT_MAX) ? stall_ticks_q + 8'd1 : stall_ticks_q;
	assign growth     = invalid_total - invalid_prev_q;

	assign flags.stall_hit = stall_next >= stall_tick_limit;
	assign flags.edge_hit  = growth > {16'd0, invalid_edge_limit};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_ticks_q  <= '0;
			invalid_prev_q <= '0;
		end else if (ctl.tick) begin
			stall_ticks_q  <= stall_next;
			invalid_prev_q <= invalid_total;
		end else if (ctl.clear) begin
			stall_ticks_q  <= '0;
			invalid_prev_q <= invalid_total;
		end
	end

endmodule

FILE: rtl/core/dfm_merge.sv
module dfm_merge (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dfm_pkg::ctl_t        ctl,
	input  logic                 line_present,
	input  logic                 imu_ready,
	input  logic [4:0]           extra_fault_bits,
	input  logic [7:0]           line_lost_tick_limit,
	input  dfm_pkg::lane_flags_t left_flags,
	input  dfm_pkg::lane_flags_t right_flags,
	output dfm_pkg::result_t     res_next,
	output logic [4:0]           faults_cur
);
	import dfm_pkg::*;

	logic [4:0] faults_q;
	logic [7:0] line_lost_q;
	logic [4:0] faults_next;
	logic [7:0] line_next;

	always_comb begin
		faults_next = faults_q;
		line_next   = line_lost_q;
		if (ctl.tick) begin
			if (line_present) begin
				line_next = '0;
			end else if (line_lost_q < COUNT_MAX) begin
				line_next = line_lost_q + 8'd1;
			end
			if (line_next >= line_lost_tick_limit) begin
				faults_next[FAULT_LINE_LOST] = 1'b1;
			end
			if (!imu_ready) begin
				faults_next[FAULT_IMU] = 1'b1;
			end
			if (left_flags.stall_hit) begin
				faults_next[FAULT_L_STALL] = 1'b1;
			end
			if (right_flags.stall_hit) begin
				faults_next[FAULT_R_STALL] = 1'b1;
			end
			if (left_flags.edge_hit || right_flags.edge_hit) begin
				faults_next[FAULT_ENC_SIG] = 1'b1;
			end
		end else if (ctl.latch) begin
			faults_next = faults_q | extra_fault_bits;
		end else if (ctl.clear) begin
			faults_next = '0;
			line_next   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			faults_q    <= '0;
			line_lost_q <= '0;
		end else begin
			faults_q    <= faults_next;
			line_lost_q <= line_next;
		end
	end

	assign res_next.faults          = faults_next;
	assign res_next.line_lost_count = line_next;
	assign faults_cur               = faults_q;

endmodule

FILE: rtl/core/dfm_out_buf.sv
module dfm_out_buf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  dfm_pkg::result_t push_data,
	output logic             can_push,
	output logic             out_valid,
	input  logic             out_ready,
	output dfm_pkg::result_t out_data,
	output logic             skid_valid
);
	import dfm_pkg::*;

	logic    out_valid_q;
	logic    skid_valid_q;
	result_t out_q;
	result_t skid_q;
	logic    out_take;
	logic    load_out;
	logic    load_skid;

	assign out_take  = out_valid_q && out_ready;
	// a new beat lands in the output register when it is free, else in the skid
	assign load_out  = push && (!out_valid_q || out_take);
	assign load_skid = push && out_valid_q && !out_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (load_skid) begin
			skid_valid_q <= 1'b1;
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_take) begin
				out_q <= skid_q;
			end
		end else if (load_out) begin
			out_q <= push_data;
		end else if (load_skid) begin
			skid_q <= push_data;
		end
	end

	assign can_push   = !skid_valid_q;
	assign out_valid  = out_valid_q;
	assign out_data   = out_q;
	assign skid_valid = skid_valid_q;

endmodule

FILE: rtl/core/drive_fault_monitor.sv
// Sticky fault monitor for a two-wheel chassis. Each input beat is one command: tick updates the
// line-lost and per-wheel stall counters (saturating at 255) and checks imu_ready and
// invalid-edge growth, latch ORs extra_fault_bits into the fault latch, clear zeroes latch and
// counters and captures the invalid-edge totals as the new reference; any other cmd code leaves
// state alone. Every beat yields exactly one result holding the faults and line-lost count after
// the command. Throughput is one beat per clock: both wheels are checked by parallel lanes and
// merged into the latch in the cycle of acceptance, and the result sits in an output register
// backed by a skid register, so item.ready drops only while both hold unread results.
// Configuration goes through the APB port at byte addresses 0, 4, 8, 12 and should only be
// written while the block is idle.
module drive_fault_monitor (
	input  logic        clk,
	input  logic        arst_n,
	dfm_in_if.sink      item,
	dfm_out_if.source   result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import dfm_pkg::*;

	logic [14:0] stall_drive_threshold_q;
	logic [7:0]  stall_tick_limit_q;
	logic [7:0]  line_lost_tick_limit_q;
	logic [15:0] invalid_edge_limit_q;

	logic        cfg_wr;
	logic [1:0]  reg_idx;
	logic        acc;
	logic        can_push;
	logic        skid_valid;
	ctl_t        ctl;
	lane_flags_t left_flags;
	lane_flags_t right_flags;
	result_t     res_next;
	result_t     out_data;
	logic [4:0]  faults_cur;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_drive_threshold_q <= RST_STALL_DRIVE_THRESHOLD;
			stall_tick_limit_q      <= RST_STALL_TICK_LIMIT;
			line_lost_tick_limit_q  <= RST_LINE_LOST_TICK_LIMIT;
			invalid_edge_limit_q    <= RST_INVALID_EDGE_LIMIT;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_STALL_DRIVE_THRESHOLD: stall_drive_threshold_q <= pwdata[14:0];
				REG_STALL_TICK_LIMIT:      stall_tick_limit_q      <= pwdata[7:0];
				REG_LINE_LOST_TICK_LIMIT:  line_lost_tick_limit_q  <= pwdata[7:0];
				REG_INVALID_EDGE_LIMIT:    invalid_edge_limit_q    <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_STALL_DRIVE_THRESHOLD: prdata = {17'd0, stall_drive_threshold_q};
			REG_STALL_TICK_LIMIT:      prdata = {24'd0, stall_tick_limit_q};
			REG_LINE_LOST_TICK_LIMIT:  prdata = {24'd0, line_lost_tick_limit_q};
			REG_INVALID_EDGE_LIMIT:    prdata = {16'd0, invalid_edge_limit_q};
			default:                   prdata = '0;
		endcase
	end

	assign item.ready = can_push;
	assign acc        = item.valid && item.ready;
	assign ctl.tick   = acc && (item.cmd == CMD_TICK);
	assign ctl.latch  = acc && (item.cmd == CMD_LATCH);
	assign ctl.clear  = acc && (item.cmd == CMD_CLEAR);

	dfm_wheel_lane u_left_lane (
		.clk                   (clk),
		.arst_n                (arst_n),
		.ctl                   (ctl),
		.drive                 (item.left_drive),
		.encoder_delta         (item.left_encoder_delta),
		.invalid_total         (item.left_invalid_total),
		.stall_drive_threshold (stall_drive_threshold_q),
		.stall_tick_limit      (stall_tick_limit_q),
		.invalid_edge_limit    (invalid_edge_limit_q),
		.flags                 (left_flags)
	);

	dfm_wheel_lane u_right_lane (
		.clk                   (clk),
		.arst_n                (arst_n),
		.ctl                   (ctl),
		.drive                 (item.right_drive),
		.encoder_delta         (item.right_encoder_delta),
		.invalid_total         (item.right_invalid_total),
		.stall_drive_threshold (stall_drive_threshold_q),
		.stall_tick_limit      (stall_tick_limit_q),
		.invalid_edge_limit    (invalid_edge_limit_q),
		.flags                 (right_flags)
	);

	dfm_merge u_merge (
		.clk                  (clk),
		.arst_n               (arst_n),
		.ctl                  (ctl),
		.line_present         (item.line_present),
		.imu_ready            (item.imu_ready),
		.extra_fault_bits     (item.extra_fault_bits),
		.line_lost_tick_limit (line_lost_tick_limit_q),
		.left_flags           (left_flags),
		.right_flags          (right_flags),
		.res_next             (res_next),
		.faults_cur           (faults_cur)
	);

	dfm_out_buf u_out_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (acc),
		.push_data  (res_next),
		.can_push   (can_push),
		.out_valid  (result.valid),
		.out_ready  (result.ready),
		.out_data   (out_data),
		.skid_valid (skid_valid)
	);

	assign result.faults          = out_data.faults;
	assign result.line_lost_count = out_data.line_lost_count;

	// skid register only fills behind a waiting output beat
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid |-> result.valid)
		else $error("skid register holds a beat while output register is empty");

	a_clear_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.clear |=> (faults_cur == '0))
		else $error("fault latch not cleared by clear command");

	a_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!ctl.clear |=> ((faults_cur & $past(faults_cur)) == $past(faults_cur)))
		else $error("fault bit dropped without clear command");

	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> result.valid)
		else $error("accepted beat produced no result");

endmodule
